/* sv/uart_idle_timeout_frame_receiver_defines.svh */
// Assertion macros shared by the frame receiver checker.
// No dependencies; include by bare file name.
`ifndef UART_IDLE_TIMEOUT_FRAME_RECEIVER_DEFINES_SVH
`define UART_IDLE_TIMEOUT_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define UITFR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define UITFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked on every edge, reset included.
`define UITFR_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/uitfr_pkg.sv */
// Shared types and constants for the UART idle-timeout frame receiver.
// No dependencies.
package uitfr_pkg;

    localparam int STORE_SIZE_DEF = 256;
    localparam logic [15:0] IDLE_TICKS_RESET = 16'd500;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    // Result word fields
    typedef struct packed {
        logic       frame_done;
        logic [7:0] frame_length;
        logic [7:0] read_data;
    } result_t;

endpackage

/* sv/uitfr_front.sv */
// Front end: accepts input words, decodes the operation, queues them.
// Depends on uitfr_pkg.
module uitfr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        s_tuser,
    input  logic [15:0]       s_tdata,
    output uitfr_pkg::q_head_t head,
    input  logic              pop
);

    uitfr_pkg::item_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic             do_pop;
    uitfr_pkg::item_t in_item;

    always_comb begin
        in_item.op         = uitfr_pkg::op_t'(s_tuser);
        in_item.rx_byte    = s_tdata[7:0];
        in_item.read_index = s_tdata[15:8];
    end

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* sv/uitfr_back.sv */
// Back end: frame store, byte count, idle timer and the result register.
// Depends on uitfr_pkg.
module uitfr_back #(
    parameter int STORE_SIZE = uitfr_pkg::STORE_SIZE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  uitfr_pkg::q_head_t head,
    output logic               pop,
    input  logic               cfg_valid,
    input  logic [15:0]        cfg_data,
    output logic               res_valid,
    input  logic               res_ready,
    output uitfr_pkg::result_t res
);

    localparam int CW   = $clog2(STORE_SIZE);
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] LAST = CW'(STORE_SIZE - 1);

    logic [7:0]    store_mem [STORE_SIZE];
    logic [7:0]    mem_q_reg;

    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic          done_reg, done_next;
    logic          run_reg, run_next;
    logic [15:0]   idle_count_reg, idle_count_next;
    logic [15:0]   idle_ticks_reg;

    logic          m_valid_reg;
    logic          out_done_reg;
    logic [7:0]    out_len_reg;
    logic          rd_ok_reg, rd_ok_next;

    logic          adv;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    logic [CW-1:0] rd_addr;
    logic [CMPW-1:0] idx_ext;
    logic [CMPW-1:0] cnt_ext;
    logic [CMPW-1:0] len_ext;
    logic [15:0]   limit;
    logic [15:0]   idle_inc;
    logic          tick_hit;

    assign adv = !m_valid_reg || res_ready;
    assign pop = head.valid && adv;

    assign idx_ext  = CMPW'(head.item.read_index);
    assign cnt_ext  = CMPW'(byte_count_reg);
    assign rd_addr  = idx_ext[CW-1:0];
    assign limit    = (idle_ticks_reg == 16'd0) ? 16'd1 : idle_ticks_reg;
    assign idle_inc = idle_count_reg + 16'd1;
    assign tick_hit = (idle_inc >= limit) || (idle_inc == 16'd0);

    always_comb begin
        byte_count_next = byte_count_reg;
        done_next       = done_reg;
        run_next        = run_reg;
        idle_count_next = idle_count_reg;
        rd_ok_next      = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = byte_count_reg;
        if (pop) begin
            case (head.item.op)
                uitfr_pkg::OP_BYTE: begin
                    wr_en = 1'b1;
                    if (byte_count_reg != LAST) begin
                        idle_count_next = 16'd0;
                        if (byte_count_reg == '0) begin
                            run_next = 1'b1;
                        end
                        byte_count_next = byte_count_reg + CW'(1);
                    end else begin
                        // Store full: wrap to the first slot, timer untouched
                        wr_addr         = '0;
                        byte_count_next = CW'(1);
                    end
                end
                uitfr_pkg::OP_TICK: begin
                    if (run_reg) begin
                        if (tick_hit) begin
                            done_next       = 1'b1;
                            run_next        = 1'b0;
                            idle_count_next = 16'd0;
                        end else begin
                            idle_count_next = idle_inc;
                        end
                    end
                end
                uitfr_pkg::OP_RESTART: begin
                    byte_count_next = '0;
                    done_next       = 1'b0;
                end
                uitfr_pkg::OP_READ: begin
                    rd_ok_next = done_reg && (idx_ext < cnt_ext);
                end
                default: begin
                end
            endcase
        end
    end

    assign len_ext = CMPW'(byte_count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            done_reg       <= 1'b0;
            run_reg        <= 1'b0;
            idle_count_reg <= 16'd0;
            idle_ticks_reg <= uitfr_pkg::IDLE_TICKS_RESET;
            m_valid_reg    <= 1'b0;
            rd_ok_reg      <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            done_reg       <= done_next;
            run_reg        <= run_next;
            idle_count_reg <= idle_count_next;
            if (cfg_valid) begin
                idle_ticks_reg <= cfg_data;
            end
            if (adv) begin
                m_valid_reg <= pop;
                rd_ok_reg   <= rd_ok_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_done_reg <= done_next;
            out_len_reg  <= done_next ? len_ext[7:0] : 8'd0;
        end
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= head.item.rx_byte;
        end
        if (pop && (head.item.op == uitfr_pkg::OP_READ)) begin
            mem_q_reg <= store_mem[rd_addr];
        end
    end

    assign res_valid         = m_valid_reg;
    assign res.frame_done    = out_done_reg;
    assign res.frame_length  = out_len_reg;
    assign res.read_data     = rd_ok_reg ? mem_q_reg : 8'd0;

endmodule

/* sv/uart_idle_timeout_frame_receiver.sv */
// Top level of the UART idle-timeout frame receiver.
// Depends on uitfr_pkg, uitfr_front and uitfr_back.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid/s_tready    s_tuser op, s_tdata rx_byte, read_index
//  m_        out        m_tvalid/m_tready    m_tdata frame_done, frame_length, read_data
//  cfg_      in         cfg_valid/cfg_ready  cfg_data idle_ticks
//
// One word per cycle sustained while m_ does not stall; each word passes
// through the two-entry queue and then the result register, which also
// holds the frame store's read port output.
// aresetn is synchronous, active low; it clears counters, flags, the queue
// and idle_ticks (to 500). The frame store keeps its contents.
// s_tready drops only when the queue is full; m_ stalls back up into it.
module uart_idle_timeout_frame_receiver #(
    parameter int STORE_SIZE = uitfr_pkg::STORE_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] read_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] frame_done, [8:1] frame_length,
                                   // [16:9] read_data, [23:17] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // [15:0] idle_ticks
);

    uitfr_pkg::q_head_t head;
    uitfr_pkg::result_t res;
    logic               pop;

    // Register writes are always accepted; cfg_data is registered into idle_ticks
    assign cfg_ready = 1'b1;

    // Accept and decode words, hold them until the back end pops
    uitfr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    // Update frame state and produce one result word per item
    uitfr_back #(
        .STORE_SIZE (STORE_SIZE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result word, lowest field first
    assign m_tdata = {7'd0, res.read_data, res.frame_length, res.frame_done};

endmodule

/* sv/uitfr_checker.sv */
// Port-level checker for the frame receiver, bound to the top level.
// Depends on uart_idle_timeout_frame_receiver_defines.svh.
`include "uart_idle_timeout_frame_receiver_defines.svh"

module uitfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // An open frame reports no length and no data
    `UITFR_ASSERT_NOW(a_open_frame_zero, aclk, aresetn,
        m_tvalid && !m_tdata[0], m_tdata[16:1] == 16'd0,
        "length or data while frame not done")

    // Padding bits stay zero
    `UITFR_ASSERT_NOW(a_pad_zero, aclk, aresetn,
        m_tvalid, m_tdata[23:17] == 7'd0, "nonzero pad bits")

    // A stalled result word holds
    `UITFR_ASSERT_NEXT(a_hold_stall, aclk, aresetn,
        m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result word changed under stall")

    // Nothing comes out right after reset
    `UITFR_ASSERT_ALWAYS(a_reset_quiet, aclk,
        $past(!aresetn), !m_tvalid, "result valid right after reset")

endmodule

bind uart_idle_timeout_frame_receiver uitfr_checker u_uitfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
